>>> rtl/core/swv_pkg.sv
// Shared types and constants for the sliding window variance block.
package swv_pkg;

	// Default sizes
	localparam int MAX_WINDOW_DEF  = 1024;
	localparam int SAMPLE_BITS_DEF = 24;

	// Register widths and port widths
	localparam int WIN_LEN_W  = 11;
	localparam int RECIP_W    = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int VAR_W      = 63;
	localparam int FRAC_BITS  = 16;

	// Running sums are kept at most one machine word wide
	localparam int ACC_W = 64;

	// Beats the front may hold between its input and the back end
	localparam int QUEUE_DEPTH = 4;

	// Register reset values
	localparam logic [WIN_LEN_W-1:0] WIN_LEN_RST          = 11'd10;
	localparam logic [RECIP_W-1:0]   RECIP_LEN_M1_RST     = 32'd477218588;
	localparam logic [RECIP_W-1:0]   RECIP_LEN_LEN_M1_RST = 32'd47721859;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RECIP_LEN_M1     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RECIP_LEN_LEN_M1 = 2'd2;

	// Saturation value of the result
	localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

	// Reciprocal factors handed to the back end
	typedef struct packed {
		logic [RECIP_W-1:0] len_m1;
		logic [RECIP_W-1:0] len_len_m1;
	} recip_t;

endpackage

>>> rtl/core/sliding_window_variance.sv
// Sliding window variance: top level with configuration registers.
//
// Input channel (push/full): one signed sample per beat plus a restart flag.
// A beat with restart set starts a new series; that sample becomes the
// reference and the window empties. Each sample's deviation goes to a ring
// of MAX_WINDOW entries; once window_len deviations are held, every beat
// yields one variance beat (16 fraction bits, clamped to 0 and 2^63-1).
// Result channel (empty/pop): the oldest result sits on variance while empty
// is low and leaves on pop.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Writing window_len empties the window, keeps the reference.
// Throughput is one sample per cycle while results are popped: the ring
// updates in one pass per sample and the multiplies run in a six-stage
// back pipeline. full rises when the 4-entry queue plus the two front
// stages in flight could overrun it; a stalled result holds the back
// pipeline and, through the queue, the input. Reset clears sums, counts,
// reference and all valids; the ring needs no clearing pass.
module sliding_window_variance #(
	parameter int MAX_WINDOW  = swv_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = swv_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// sample channel
	input  logic                                push,
	output logic                                full,
	input  logic signed [SAMPLE_BITS-1:0]       sample,
	input  logic                                restart,
	// result channel
	output logic                                empty,
	input  logic                                pop,
	output logic [swv_pkg::VAR_W-1:0]           variance,
	// configuration channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [swv_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [swv_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int DEV_W  = SAMPLE_BITS + 1;
	localparam int SD_RAW = DEV_W + $clog2(MAX_WINDOW);
	localparam int SQ_RAW = 2 * DEV_W + $clog2(MAX_WINDOW);
	localparam int SD_W   = (SD_RAW > swv_pkg::ACC_W) ? swv_pkg::ACC_W : SD_RAW;
	localparam int SQ_W   = (SQ_RAW > swv_pkg::ACC_W) ? swv_pkg::ACC_W : SQ_RAW;
	localparam int QD     = swv_pkg::QUEUE_DEPTH;
	localparam int QCW    = $clog2(QD + 1);

	// Configuration registers
	logic [swv_pkg::WIN_LEN_W-1:0] window_len_q;
	swv_pkg::recip_t               recip_q;
	logic                          win_clear;

	assign cfg_ready = 1'b1;
	assign win_clear = cfg_valid && (cfg_index == swv_pkg::CFG_WINDOW_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q      <= swv_pkg::WIN_LEN_RST;
			recip_q.len_m1     <= swv_pkg::RECIP_LEN_M1_RST;
			recip_q.len_len_m1 <= swv_pkg::RECIP_LEN_LEN_M1_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				swv_pkg::CFG_WINDOW_LEN: begin
					window_len_q <= cfg_data[swv_pkg::WIN_LEN_W-1:0];
				end
				swv_pkg::CFG_RECIP_LEN_M1: begin
					recip_q.len_m1 <= cfg_data[swv_pkg::RECIP_W-1:0];
				end
				swv_pkg::CFG_RECIP_LEN_LEN_M1: begin
					recip_q.len_len_m1 <= cfg_data[swv_pkg::RECIP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Front end
	logic                  q_push;
	logic [SQ_W+SD_W-1:0]  q_wdata;
	logic [SQ_W+SD_W-1:0]  q_rdata;
	logic                  q_pop;
	logic                  q_valid;
	logic [QCW-1:0]        q_count;

	swv_front #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS),
		.SD_W        (SD_W),
		.SQ_W        (SQ_W),
		.QUEUE_DEPTH (QD)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.sample     (sample),
		.restart    (restart),
		.window_len (window_len_q),
		.win_clear  (win_clear),
		.q_count    (q_count),
		.q_push     (q_push),
		.q_data     (q_wdata)
	);

	// Queue between the two halves
	swv_fifo #(
		.WIDTH (SQ_W + SD_W),
		.DEPTH (QD)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.not_empty (q_valid),
		.count     (q_count)
	);

	// Back end
	swv_back #(
		.SD_W (SD_W),
		.SQ_W (SQ_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.recip    (recip_q),
		.q_valid  (q_valid),
		.q_data   (q_rdata),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.variance (variance)
	);

endmodule

>>> rtl/core/swv_ram.sv
// Generic single write port, single read port RAM with registered read (read-first).
module swv_ram #(
	parameter int WIDTH = 25,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Same-address read returns the old contents
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/core/swv_front.sv
// Front end: takes samples, keeps the deviation ring and the running sums.
module swv_front #(
	parameter int MAX_WINDOW  = swv_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = swv_pkg::SAMPLE_BITS_DEF,
	parameter int SD_W        = 35,
	parameter int SQ_W        = 60,
	parameter int QUEUE_DEPTH = swv_pkg::QUEUE_DEPTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// sample channel
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [SAMPLE_BITS-1:0]        sample,
	input  logic                                 restart,
	// window settings
	input  logic [swv_pkg::WIN_LEN_W-1:0]        window_len,
	input  logic                                 win_clear,
	// queue towards the back end
	input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     q_count,
	output logic                                 q_push,
	output logic [SQ_W+SD_W-1:0]                 q_data
);

	localparam int DEV_W = SAMPLE_BITS + 1;
	localparam int AW    = $clog2(MAX_WINDOW);
	localparam int LW    = $clog2(MAX_WINDOW + 1);
	localparam int CW    = (LW > swv_pkg::WIN_LEN_W) ? LW : swv_pkg::WIN_LEN_W;
	localparam int PW    = 2 * DEV_W;
	localparam int QCW   = $clog2(QUEUE_DEPTH + 1);

	// Effective window length, clamped to [2, MAX_WINDOW]
	logic [CW-1:0] len_ext;
	logic [LW-1:0] len_eff;

	assign len_ext = CW'(window_len);

	always_comb begin
		if (len_ext < CW'(2)) begin
			len_eff = LW'(2);
		end else if (len_ext > CW'(MAX_WINDOW)) begin
			len_eff = LW'(MAX_WINDOW);
		end else begin
			len_eff = LW'(len_ext);
		end
	end

	// Series state
	logic signed [SAMPLE_BITS-1:0] ref_q;
	logic [AW-1:0]                 wr_idx_q;
	logic [LW-1:0]                 fill_q;

	// Accept-cycle decode
	logic                          accept;
	logic signed [SAMPLE_BITS-1:0] ref_eff;
	logic signed [DEV_W-1:0]       dev;
	logic [AW-1:0]                 wr_base;
	logic [AW-1:0]                 idx;
	logic [LW-1:0]                 idx_inc;
	logic [AW-1:0]                 wr_next;
	logic [LW-1:0]                 fill_base;
	logic                          remove;
	logic [LW-1:0]                 fill_next;
	logic                          emit;
	logic [QCW:0]                  credit;

	// Pipeline valids
	logic v_s1;
	logic v_s2;

	// Room in the queue for this beat and everything still in flight
	assign credit = {1'b0, q_count} + (QCW+1)'(v_s1) + (QCW+1)'(v_s2);
	assign full   = credit >= (QCW+1)'(QUEUE_DEPTH);
	assign accept = push && !full;

	always_comb begin
		ref_eff   = restart ? sample : ref_q;
		dev       = DEV_W'(sample) - DEV_W'(ref_eff);
		wr_base   = restart ? '0 : wr_idx_q;
		idx       = (LW'(wr_base) >= len_eff) ? '0 : wr_base;
		idx_inc   = LW'(idx) + LW'(1);
		wr_next   = (idx_inc >= len_eff) ? '0 : AW'(idx_inc);
		fill_base = restart ? '0 : fill_q;
		remove    = fill_base >= len_eff;
		fill_next = remove ? len_eff : fill_base + LW'(1);
		emit      = fill_next == len_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q    <= '0;
			wr_idx_q <= '0;
			fill_q   <= '0;
		end else if (win_clear) begin
			wr_idx_q <= '0;
			fill_q   <= '0;
		end else if (accept) begin
			if (restart) begin
				ref_q <= sample;
			end
			wr_idx_q <= wr_next;
			fill_q   <= fill_next;
		end
	end

	// Deviation ring: new deviation written, oldest read at the same slot
	logic [DEV_W-1:0] ring_rd;

	swv_ram #(
		.WIDTH (DEV_W),
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (idx),
		.wr_data (dev),
		.rd_en   (accept),
		.rd_addr (idx),
		.rd_data (ring_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	// Stage 1: deviation and flags, oldest deviation arrives from the ring
	logic signed [DEV_W-1:0] dev_s1;
	logic                    remove_s1;
	logic                    clear_s1;
	logic                    emit_s1;
	logic signed [DEV_W-1:0] old_dev;
	logic signed [PW-1:0]    dev_sq;
	logic signed [PW-1:0]    old_sq;

	always_ff @(posedge clk) begin
		if (accept) begin
			dev_s1    <= dev;
			remove_s1 <= remove;
			clear_s1  <= restart;
			emit_s1   <= emit;
		end
	end

	always_comb begin
		old_dev = $signed(ring_rd);
		dev_sq  = dev_s1 * dev_s1;
		old_sq  = old_dev * old_dev;
	end

	// Stage 2: squares registered
	logic signed [DEV_W-1:0] dev_s2;
	logic signed [DEV_W-1:0] old_s2;
	logic [SQ_W-1:0]         dev_sq_s2;
	logic [SQ_W-1:0]         old_sq_s2;
	logic                    remove_s2;
	logic                    clear_s2;
	logic                    emit_s2;

	always_ff @(posedge clk) begin
		if (v_s1) begin
			dev_s2    <= dev_s1;
			old_s2    <= old_dev;
			dev_sq_s2 <= SQ_W'($unsigned(dev_sq));
			old_sq_s2 <= SQ_W'($unsigned(old_sq));
			remove_s2 <= remove_s1;
			clear_s2  <= clear_s1;
			emit_s2   <= emit_s1;
		end
	end

	// Running sums: drop the oldest deviation, add the new one
	logic signed [SD_W-1:0] sum_dev_q;
	logic [SQ_W-1:0]        sum_sq_q;
	logic signed [SD_W-1:0] sd_base;
	logic signed [SD_W-1:0] sd_next;
	logic [SQ_W-1:0]        sq_base;
	logic [SQ_W-1:0]        sq_next;

	always_comb begin
		sd_base = clear_s2 ? '0 : sum_dev_q;
		sq_base = clear_s2 ? '0 : sum_sq_q;
		sd_next = sd_base - (remove_s2 ? SD_W'(old_s2) : '0) + SD_W'(dev_s2);
		sq_next = sq_base - (remove_s2 ? old_sq_s2 : '0) + dev_sq_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_dev_q <= '0;
			sum_sq_q  <= '0;
		end else if (win_clear) begin
			sum_dev_q <= '0;
			sum_sq_q  <= '0;
		end else if (v_s2) begin
			sum_dev_q <= sd_next;
			sum_sq_q  <= sq_next;
		end
	end

	// Full window: hand the sums to the back end
	assign q_push = v_s2 && emit_s2;
	assign q_data = {sq_next, sd_next};

endmodule

>>> rtl/core/swv_fifo.sv
// Short register queue between the front and back ends.
module swv_fifo #(
	parameter int WIDTH = 95,
	parameter int DEPTH = swv_pkg::QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [WIDTH-1:0]             push_data,
	input  logic                         pop,
	output logic [WIDTH-1:0]             pop_data,
	output logic                         not_empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign do_push   = push && (count_q != CNT_W'(DEPTH));
	assign do_pop    = pop && (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign count     = count_q;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/core/swv_back.sv
// Back end: variance from the running sums, multiplies split into 32x32 partial products.
module swv_back #(
	parameter int SD_W = 35,
	parameter int SQ_W = 60
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  swv_pkg::recip_t             recip,
	// queue side
	input  logic                        q_valid,
	input  logic [SQ_W+SD_W-1:0]        q_data,
	output logic                        q_pop,
	// result channel
	output logic                        empty,
	input  logic                        pop,
	output logic [swv_pkg::VAR_W-1:0]   variance
);

	localparam int ACC_W = swv_pkg::ACC_W;
	localparam int HW    = ACC_W / 2;
	localparam int A_W   = ACC_W + swv_pkg::RECIP_W;
	localparam int SQR_W = 2 * ACC_W;
	localparam int B_W   = SQR_W + swv_pkg::RECIP_W;
	localparam int NLIMB = SQR_W / HW;
	localparam int LO    = swv_pkg::FRAC_BITS;
	localparam int HI    = swv_pkg::FRAC_BITS + swv_pkg::VAR_W;

	logic adv;
	logic out_v_q;
	logic v_b1, v_b2, v_b3, v_b4, v_b5;

	// Whole pipe moves when the result slot is free or being taken
	assign adv   = !out_v_q || pop;
	assign q_pop = adv && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1    <= 1'b0;
			v_b2    <= 1'b0;
			v_b3    <= 1'b0;
			v_b4    <= 1'b0;
			v_b5    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_b1    <= q_valid;
			v_b2    <= v_b1;
			v_b3    <= v_b2;
			v_b4    <= v_b3;
			v_b5    <= v_b4;
			out_v_q <= v_b5;
		end
	end

	// Stage 1: widen sum of squares, magnitude of the sum
	logic signed [SD_W-1:0] sd;
	logic [ACC_W-1:0]       sd64;
	logic [ACC_W-1:0]       mag;
	logic [ACC_W-1:0]       s2_b1;
	logic [ACC_W-1:0]       mag_b1;

	always_comb begin
		sd   = $signed(q_data[SD_W-1:0]);
		sd64 = ACC_W'(sd);
		mag  = sd64[ACC_W-1] ? (ACC_W'(0) - sd64) : sd64;
	end

	// Stage 2: partial products of S2*p1 and |S1|^2
	logic [ACC_W-1:0] pa0_b2, pa1_b2;
	logic [ACC_W-1:0] ml_b2, mx_b2, mh_b2;

	// Stage 3: assembled products
	logic [A_W-1:0]   a_b3;
	logic [SQR_W-1:0] sq_b3;

	// Stage 4: partial products of |S1|^2 * p2
	logic [A_W-1:0]   a_b4;
	logic [ACC_W-1:0] pb_b4 [NLIMB];

	// Stage 5: both products complete
	logic [A_W-1:0]   a_b5;
	logic [B_W-1:0]   b_b5;
	logic [B_W-1:0]   b_sum;

	always_comb begin
		b_sum = '0;
		for (int k = 0; k < NLIMB; k++) begin
			b_sum = b_sum + (B_W'(pb_b4[k]) << (HW * k));
		end
	end

	// Final difference, clamp at zero and at the maximum
	logic [B_W:0]                diff;
	logic [swv_pkg::VAR_W-1:0]   res;

	always_comb begin
		diff = {1'b0, B_W'(a_b5)} - {1'b0, b_b5};
		if (diff[B_W]) begin
			res = '0;
		end else if (|diff[B_W-1:HI]) begin
			res = swv_pkg::VAR_MAX;
		end else begin
			res = diff[HI-1:LO];
		end
	end

	logic [swv_pkg::VAR_W-1:0] out_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			s2_b1  <= ACC_W'(q_data[SQ_W+SD_W-1:SD_W]);
			mag_b1 <= mag;

			pa0_b2 <= ACC_W'(s2_b1[HW-1:0] * recip.len_m1);
			pa1_b2 <= ACC_W'(s2_b1[ACC_W-1:HW] * recip.len_m1);
			ml_b2  <= mag_b1[HW-1:0] * mag_b1[HW-1:0];
			mx_b2  <= mag_b1[HW-1:0] * mag_b1[ACC_W-1:HW];
			mh_b2  <= mag_b1[ACC_W-1:HW] * mag_b1[ACC_W-1:HW];

			a_b3  <= A_W'(pa0_b2) + (A_W'(pa1_b2) << HW);
			sq_b3 <= SQR_W'(ml_b2) + (SQR_W'(mx_b2) << (HW + 1)) + {mh_b2, {ACC_W{1'b0}}};

			a_b4 <= a_b3;
			for (int k = 0; k < NLIMB; k++) begin
				pb_b4[k] <= ACC_W'(sq_b3[HW*k +: HW] * recip.len_len_m1);
			end

			a_b5 <= a_b4;
			b_b5 <= b_sum;

			out_q <= res;
		end
	end

	assign empty    = !out_v_q;
	assign variance = out_q;

endmodule
